// ===== sv/tcf_pkg.sv =====
// shared types, constants and the cordic arctangent table for the tilt filter
package tcf_pkg;

    localparam int ANGLE_W        = 16;
    localparam int TIME_W         = 32;
    localparam int GAIN_W         = 20;
    localparam int CFG_DATA_W     = 20;
    localparam int CFG_IDX_W      = 2;
    localparam int ACC_W          = 32;
    localparam int CORDIC_W       = 27;
    localparam int MUL_A_W        = 37;
    localparam int MUL_B_W        = 17;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
    localparam int PROD_W         = 48;
    localparam int ATAN_TABLE_SIZE = 24;
    localparam int TAB_IDX_W      = 5;
    localparam int DEF_CORDIC_STEPS = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 2'd2;

    localparam logic [15:0] RST_ANGLE_OFFSET = 16'd0;
    localparam logic [15:0] RST_BLEND_GAIN   = 16'd2621;
    localparam logic [19:0] RST_GYRO_GAIN    = 20'd47675;

    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ROUND_BIT = 32'h0000_8000;

    // shared multiplier operand select
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RATE_GAIN,
        MUL_DT_LO,
        MUL_DT_HI,
        MUL_BLEND
    } t_mul_op;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [TAB_IDX_W-1:0] step_idx;
        logic                 meas;
        t_mul_op              mul_op;
        logic                 pred;
        logic                 seed;
        logic                 commit;
    } t_cmd;

    typedef struct packed {
        logic seeded;
        logic out_free;
    } t_status;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [ACC_W-1:0] atan_turns(input logic [TAB_IDX_W-1:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/tcf_ctrl.sv =====
// sequencer for the tilt filter: cordic steps, multiply steps and write-back
module tcf_ctrl #(
    parameter int CORDIC_STEPS = tcf_pkg::DEF_CORDIC_STEPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tcf_pkg::t_status i_status,
    output tcf_pkg::t_cmd    o_cmd
);
    import tcf_pkg::*;

    localparam int STEPS  = (CORDIC_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE : CORDIC_STEPS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CORDIC = 10'b00_0000_0010,
        S_MEAS   = 10'b00_0000_0100,
        S_RG     = 10'b00_0000_1000,
        S_DLO    = 10'b00_0001_0000,
        S_DHI    = 10'b00_0010_0000,
        S_PRED   = 10'b00_0100_0000,
        S_BLEND  = 10'b00_1000_0000,
        S_SEED   = 10'b01_0000_0000,
        S_WRITE  = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.mul_op   = MUL_NONE;
        o_cmd.step_idx = TAB_IDX_W'(r_step);
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CORDIC;
                end
            end
            S_CORDIC: begin
                o_cmd.step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_MEAS;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_MEAS: begin
                o_cmd.meas = 1'b1;
                n_state = i_status.seeded ? S_RG : S_SEED;
            end
            S_RG: begin
                o_cmd.mul_op = MUL_RATE_GAIN;
                n_state = S_DLO;
            end
            S_DLO: begin
                o_cmd.mul_op = MUL_DT_LO;
                n_state = S_DHI;
            end
            S_DHI: begin
                o_cmd.mul_op = MUL_DT_HI;
                n_state = S_PRED;
            end
            S_PRED: begin
                o_cmd.pred = 1'b1;
                n_state = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.mul_op = MUL_BLEND;
                n_state = S_WRITE;
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state = S_IDLE;
            end
            S_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== sv/tcf_datapath.sv =====
// datapath: config registers, cordic vectoring unit, shared multiplier, output register
module tcf_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [tcf_pkg::ANGLE_W-1:0]  i_accel_x,
    input  logic signed [tcf_pkg::ANGLE_W-1:0]  i_accel_y,
    input  logic signed [tcf_pkg::ANGLE_W-1:0]  i_gyro_z,
    input  logic [tcf_pkg::TIME_W-1:0]          i_time_us,
    input  tcf_pkg::t_cmd                       i_cmd,
    output tcf_pkg::t_status                    o_status,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic signed [tcf_pkg::ANGLE_W-1:0]  o_tilt_angle,
    output logic signed [tcf_pkg::ANGLE_W-1:0]  o_measured_angle
);
    import tcf_pkg::*;

    // config
    logic [ANGLE_W-1:0] r_offset;
    logic [ANGLE_W-1:0] r_blend;
    logic [GAIN_W-1:0]  r_ggain;

    // per-word working registers
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic [ACC_W-1:0]           r_acc;
    logic                       r_zero;
    logic [TIME_W-1:0]          r_dt, r_time;
    logic signed [ANGLE_W-1:0]  r_rate;
    logic [MUL_A_W-1:0]         r_m1;
    logic [PROD_W-1:0]          r_p;
    logic [ANGLE_W-1:0]         r_meas, r_pred, r_corr;

    // filter state
    logic [ANGLE_W-1:0] r_prev_angle;
    logic [TIME_W-1:0]  r_prev_time;
    logic               r_seeded;

    // output register
    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_out_tilt, r_out_meas;

    logic signed [CORDIC_W-1:0] w_xs, w_ys, w_sx, w_sy;
    logic                       w_y_pos;
    logic [ACC_W-1:0]           w_acc_rnd;
    logic [ANGLE_W-1:0]         w_vec, w_meas, w_err, w_fused;
    logic signed [MUL_A_W-1:0]  w_a;
    logic signed [MUL_B_W-1:0]  w_b;
    logic signed [MUL_P_W-1:0]  w_prod;

    // vector (x, y) = (accel_y, accel_x) scaled by 256
    assign w_xs = {{(CORDIC_W-ANGLE_W-8){i_accel_y[ANGLE_W-1]}}, i_accel_y, 8'b0};
    assign w_ys = {{(CORDIC_W-ANGLE_W-8){i_accel_x[ANGLE_W-1]}}, i_accel_x, 8'b0};

    assign w_sx    = r_x >>> i_cmd.step_idx;
    assign w_sy    = r_y >>> i_cmd.step_idx;
    assign w_y_pos = !r_y[CORDIC_W-1] && (|r_y);

    assign w_acc_rnd = r_acc + ROUND_BIT;
    assign w_vec     = r_zero ? '0 : w_acc_rnd[ACC_W-1:ACC_W-ANGLE_W];
    assign w_meas    = w_vec - r_offset;
    assign w_err     = r_meas - r_pred;
    assign w_fused   = r_pred + r_corr;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_RATE_GAIN: begin
                w_a = {{(MUL_A_W-GAIN_W){1'b0}}, r_ggain};
                w_b = {r_rate[ANGLE_W-1], r_rate};
            end
            MUL_DT_LO: begin
                w_a = r_m1;
                w_b = {1'b0, r_dt[15:0]};
            end
            MUL_DT_HI: begin
                w_a = r_m1;
                w_b = {1'b0, r_dt[31:16]};
            end
            MUL_BLEND: begin
                w_a = {{(MUL_A_W-ANGLE_W){w_err[ANGLE_W-1]}}, w_err};
                w_b = {1'b0, r_blend};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= RST_ANGLE_OFFSET;
            r_blend  <= RST_BLEND_GAIN;
            r_ggain  <= RST_GYRO_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_OFFSET: r_offset <= i_cfg_data[ANGLE_W-1:0];
                REG_BLEND_GAIN:   r_blend  <= i_cfg_data[ANGLE_W-1:0];
                REG_GYRO_GAIN:    r_ggain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (i_accel_x == '0) && (i_accel_y == '0);
            r_dt   <= i_time_us - r_prev_time;
            r_time <= i_time_us;
            r_rate <= i_gyro_z;
            if (i_accel_y[ANGLE_W-1]) begin
                r_x   <= -w_xs;
                r_y   <= -w_ys;
                r_acc <= HALF_TURN;
            end else begin
                r_x   <= w_xs;
                r_y   <= w_ys;
                r_acc <= '0;
            end
        end else if (i_cmd.step) begin
            if (w_y_pos) begin
                r_x   <= r_x + w_sy;
                r_y   <= r_y - w_sx;
                r_acc <= r_acc + atan_turns(i_cmd.step_idx);
            end else begin
                r_x   <= r_x - w_sy;
                r_y   <= r_y + w_sx;
                r_acc <= r_acc - atan_turns(i_cmd.step_idx);
            end
        end
        if (i_cmd.meas) begin
            r_meas <= w_meas;
        end
        if (i_cmd.pred) begin
            r_pred <= r_prev_angle + r_p[PROD_W-1:PROD_W-ANGLE_W];
        end
        case (i_cmd.mul_op)
            MUL_RATE_GAIN: r_m1   <= w_prod[MUL_A_W-1:0];
            MUL_DT_LO:     r_p    <= w_prod[PROD_W-1:0];
            MUL_DT_HI:     r_p    <= r_p + {w_prod[31:0], 16'b0};
            MUL_BLEND:     r_corr <= w_prod[31:16];
            default: ;
        endcase
        if (i_cmd.commit) begin
            r_out_tilt <= w_fused;
            r_out_meas <= r_meas;
        end
    end

    // filter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_prev_time  <= '0;
            r_seeded     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.seed) begin
                r_prev_angle <= r_meas;
                r_prev_time  <= r_time;
                r_seeded     <= 1'b1;
            end else if (i_cmd.commit) begin
                r_prev_angle <= w_fused;
                r_prev_time  <= r_time;
            end
        end
    end

    assign o_status.seeded   = r_seeded;
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_tilt_angle     = r_out_tilt;
    assign o_measured_angle = r_out_meas;

endmodule

// ===== sv/tilt_complementary_filter_top.sv =====
// top level of the tilt complementary filter: sequencer plus datapath
//
// input channel: i_valid / o_ready carry one word of accel x, accel y, gyro z
//   and a microsecond timestamp; o_ready is high only while the block is idle
// output channel: o_valid / i_ready carry the filtered tilt angle and the
//   accelerometer angle minus offset, both 16-bit binary angles
// config: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
//   (0 angle offset, 1 blend gain, 2 gyro gain; index 3 is ignored)
// timing: after acceptance a word runs through the one-step-a-cycle cordic
//   loop, then the measured angle, four passes through the shared multiplier,
//   the prediction and the write-back; o_valid and o_ready rise together
//   after the write-back, and a new word is taken only once the previous
//   word is written back
// the first word after reset only seeds the angle and time state, no result,
//   and the next word can follow as soon as that state is seeded
// reset (synchronous, active low) clears the filter state and loads the
//   register defaults
// a stalled receiver holds the result in the output register; the next word
//   is still accepted and processed, and only its write-back waits
module tilt_complementary_filter_top #(
    parameter int CORDIC_STEPS = tcf_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input words
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [tcf_pkg::ANGLE_W-1:0]  i_accel_x,
    input  logic signed [tcf_pkg::ANGLE_W-1:0]  i_accel_y,
    input  logic signed [tcf_pkg::ANGLE_W-1:0]  i_gyro_z,
    input  logic [tcf_pkg::TIME_W-1:0]          i_time_us,
    // result words
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [tcf_pkg::ANGLE_W-1:0]  o_tilt_angle,
    output logic signed [tcf_pkg::ANGLE_W-1:0]  o_measured_angle
);
    import tcf_pkg::*;

    t_cmd    w_cmd;     // per-cycle commands from the sequencer
    t_status w_status;  // seeded flag and output register space

    tcf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tcf_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_gyro_z         (i_gyro_z),
        .i_time_us        (i_time_us),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_tilt_angle     (o_tilt_angle),
        .o_measured_angle (o_measured_angle)
    );

endmodule

// ===== bench/tilt_complementary_filter_top_tb.sv =====
// self-checking bench for the tilt complementary filter: directed and random imu words
`timescale 1ns / 1ps

module tilt_complementary_filter_top_tb;
    import tcf_pkg::*;

    localparam int FILTER_STEPS  = DEF_CORDIC_STEPS;
    // the bearing loop never runs past the end of its table
    localparam int BEARING_STEPS = (FILTER_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE
                                                                    : FILTER_STEPS;
    // the time a word spends in the filter, with margin on top
    localparam int SETTLE_CYCLES = FILTER_STEPS + 24;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int REPORT_LIMIT  = 30;

    // index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // atan(2^-i), 2^32 per turn
    localparam logic [ACC_W-1:0] STEP_TURNS [0:ATAN_TABLE_SIZE-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [ANGLE_W-1:0] ax;
        logic [ANGLE_W-1:0] ay;
        logic [ANGLE_W-1:0] gz;
        logic [TIME_W-1:0]  stamp;
        logic               drain;   // hold this word back until all angles are out
    } t_imu_word;

    typedef struct packed {
        logic [ANGLE_W-1:0] tilt;
        logic [ANGLE_W-1:0] meas;
    } t_tilt_pair;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [ANGLE_W-1:0]     i_accel_x = '0;
    logic signed [ANGLE_W-1:0]     i_accel_y = '0;
    logic signed [ANGLE_W-1:0]     i_gyro_z = '0;
    logic [TIME_W-1:0]             i_time_us = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b1;
    logic signed [ANGLE_W-1:0]     o_tilt_angle;
    logic signed [ANGLE_W-1:0]     o_measured_angle;

    tilt_complementary_filter_top #(
        .CORDIC_STEPS(FILTER_STEPS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_gyro_z        (i_gyro_z),
        .i_time_us       (i_time_us),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_tilt_angle    (o_tilt_angle),
        .o_measured_angle(o_measured_angle)
    );

    // shadow of the filter registers and state
    logic [ANGLE_W-1:0] offset_q  = RST_ANGLE_OFFSET;
    logic [15:0]        blend_q   = RST_BLEND_GAIN;
    logic [GAIN_W-1:0]  gain_q    = RST_GYRO_GAIN;
    logic [ANGLE_W-1:0] last_tilt = '0;
    logic [TIME_W-1:0]  last_stamp = '0;
    logic               primed = 1'b0;

    t_imu_word  imu_backlog_q [$];
    t_tilt_pair angle_forecast_q [$];

    t_imu_word   word_on_bus;
    int unsigned words_queued = 0;
    int unsigned words_sent = 0;
    int unsigned angles_checked = 0;
    int unsigned settings_used = 1;
    int unsigned fail_count = 0;
    int unsigned idle_odds = 0;     // percent chance per free cycle to start an idle burst
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    logic [TIME_W-1:0] stamp_cursor = '0;

    // vectoring cordic on (accel_y, accel_x), 2^32 per turn, rounded to 16 bits
    function automatic logic [ANGLE_W-1:0] accel_bearing(input logic [ANGLE_W-1:0] ax,
                                                        input logic [ANGLE_W-1:0] ay);
        longint x;
        longint y;
        longint nx;
        logic [ACC_W-1:0] acc;
        int i;
        if (ax == '0 && ay == '0)
            return '0;
        x = longint'($signed(ay)) * 256;
        y = longint'($signed(ax)) * 256;
        acc = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = HALF_TURN;
        end
        for (i = 0; i < BEARING_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                acc = acc + STEP_TURNS[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                acc = acc - STEP_TURNS[i];
            end
            x = nx;
        end
        acc = acc + ROUND_BIT;
        return acc[ACC_W-1:ACC_W-ANGLE_W];
    endfunction

    // floor(rate * dt * gain / 2^32), low 16 bits
    function automatic logic [ANGLE_W-1:0] gyro_turn(input logic [ANGLE_W-1:0] rate,
                                                    input logic [TIME_W-1:0] dt,
                                                    input logic [GAIN_W-1:0] gain);
        logic signed [127:0] prod;
        prod = $signed({{112{rate[ANGLE_W-1]}}, rate}) * $signed({96'd0, dt})
             * $signed({108'd0, gain});
        prod = prod >>> 32;
        return prod[ANGLE_W-1:0];
    endfunction

    // advance the shadow filter by one accepted word
    task automatic fuse_sample(input t_imu_word w);
        logic [ANGLE_W-1:0] meas;
        logic [ANGLE_W-1:0] pred;
        logic [ANGLE_W-1:0] diff;
        longint corr;
        t_tilt_pair e;
        meas = accel_bearing(w.ax, w.ay) - offset_q;
        if (!primed) begin
            // first word only seeds the state
            last_tilt = meas;
            last_stamp = w.stamp;
            primed = 1'b1;
            return;
        end
        pred = last_tilt + gyro_turn(w.gz, w.stamp - last_stamp, gain_q);
        diff = meas - pred;
        corr = (longint'(blend_q) * longint'($signed(diff))) >>> 16;
        e.tilt = pred + corr[ANGLE_W-1:0];
        e.meas = meas;
        last_tilt = e.tilt;
        last_stamp = w.stamp;
        angle_forecast_q.push_back(e);
    endtask

    // ---------------------------------------------------------------
    // word driver: presents the oldest backlog entry, random gaps between words
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        logic taken;
        logic launch;
        t_imu_word nxt;
        taken = i_valid && o_ready;
        launch = 1'b0;
        if (taken) begin
            fuse_sample(word_on_bus);
            words_sent++;
        end
        if (!i_valid || taken) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (i_rst_n && imu_backlog_q.size() != 0) begin
                if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
                    // this cycle is the first of the burst
                    send_gap = $urandom_range(1, 14) - 1;
                end else if (!(imu_backlog_q[0].drain && angle_forecast_q.size() != 0)) begin
                    launch = 1'b1;
                end
            end
        end
        if (launch) begin
            nxt = imu_backlog_q.pop_front();
            word_on_bus = nxt;
            i_accel_x <= nxt.ax;
            i_accel_y <= nxt.ay;
            i_gyro_z  <= nxt.gz;
            i_time_us <= nxt.stamp;
            i_valid   <= 1'b1;
        end else if (taken) begin
            i_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // result monitor: compares each accepted result with the oldest forecast,
    // and stalls the output side in random bursts
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_tilt_pair e;
        if (o_valid && i_ready) begin
            if (angle_forecast_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result with no angle expected, tilt %0d measured %0d",
                             $time, o_tilt_angle, o_measured_angle);
            end else begin
                e = angle_forecast_q.pop_front();
                angles_checked++;
                if (o_tilt_angle !== e.tilt) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: tilt_angle mismatch, expected %0d actual %0d",
                                 $time, $signed(e.tilt), o_tilt_angle);
                end
                if (o_measured_angle !== e.meas) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: measured_angle mismatch, expected %0d actual %0d",
                                 $time, $signed(e.meas), o_measured_angle);
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic queue_word(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                              input logic [ANGLE_W-1:0] gz, input logic [TIME_W-1:0] stamp,
                              input logic drain);
        t_imu_word w;
        w.ax = ax;
        w.ay = ay;
        w.gz = gz;
        w.stamp = stamp;
        w.drain = drain;
        imu_backlog_q.push_back(w);
        words_queued++;
    endtask

    // one register write per cycle, shadow follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ANGLE_OFFSET: offset_q = data[ANGLE_W-1:0];
            REG_BLEND_GAIN:   blend_q  = data[15:0];
            REG_GYRO_GAIN:    gain_q   = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_filter(input logic [CFG_DATA_W-1:0] offset_word,
                                  input logic [CFG_DATA_W-1:0] blend_word,
                                  input logic [CFG_DATA_W-1:0] gain_word);
        write_reg(REG_ANGLE_OFFSET, offset_word);
        write_reg(REG_BLEND_GAIN, blend_word);
        write_reg(REG_GYRO_GAIN, gain_word);
        // the spare index must leave every register alone
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // wait until every word is in, every angle is out and the sequencer has gone quiet
    task automatic settle();
        while (words_sent != words_queued)
            @(posedge i_clk);
        while (angle_forecast_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ANGLE_W-1:0] edge_count();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] random_count();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
            return ANGLE_W'($urandom);
        if (kind < 8)
            return ANGLE_W'($urandom_range(0, 128)) - 16'd64;
        if (kind < 9)
            return '0;
        return edge_count();
    endfunction

    task automatic queue_random_word();
        int unsigned pick;
        pick = $urandom_range(0, 59);
        // mostly forward steps of up to 5000 us, sometimes jumps, repeats and steps back
        if (pick < 4)
            stamp_cursor = $urandom;
        else if (pick < 7)
            stamp_cursor = stamp_cursor - TIME_W'($urandom_range(1, 3000));
        else if (pick < 10)
            stamp_cursor = stamp_cursor;
        else
            stamp_cursor = stamp_cursor + TIME_W'($urandom_range(1, 5000));
        queue_word(random_count(), random_count(),
                   ($urandom_range(0, 3) == 0) ? edge_count() : ANGLE_W'($urandom),
                   stamp_cursor, $urandom_range(0, 39) == 0);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            queue_random_word();
    endtask

    // ---------------------------------------------------------------
    // stimulus: reset, directed corners at reset defaults, then random phases
    // ---------------------------------------------------------------
    initial begin : stimulus
        int unsigned p;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values; first word seeds from a zero vector
        idle_odds = 20;
        queue_word(16'h0000, 16'h0000, 16'h0000, 32'd0,          1'b0);
        queue_word(16'h0000, 16'h0000, 16'h0000, 32'd1000,       1'b0);
        queue_word(16'h7FFF, 16'h0000, 16'h0000, 32'd2000,       1'b0);
        queue_word(16'h8000, 16'h0000, 16'h0000, 32'd3000,       1'b0);
        queue_word(16'h0000, 16'h7FFF, 16'h0000, 32'd4000,       1'b0);
        queue_word(16'h0000, 16'h8000, 16'h0000, 32'd5000,       1'b0);
        queue_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd6000,       1'b0);
        queue_word(16'h8000, 16'h8000, 16'h8000, 32'd7000,       1'b0);
        queue_word(16'h8000, 16'h7FFF, 16'h0001, 32'd8000,       1'b1);
        queue_word(16'h7FFF, 16'h8000, 16'hFFFF, 32'd9000,       1'b0);
        // either side of the half turn
        queue_word(16'h0001, 16'h8000, 16'h0000, 32'd10000,      1'b0);
        queue_word(16'hFFFF, 16'h8000, 16'h0000, 32'd11000,      1'b0);
        queue_word(16'h0000, 16'hFFFF, 16'h0000, 32'd12000,      1'b0);
        queue_word(16'hFFFF, 16'h0000, 16'h0000, 32'd13000,      1'b0);
        // full-scale rates over long intervals
        queue_word(16'h1234, 16'h4321, 16'h7FFF, 32'h7FFF_FFFF,  1'b0);
        queue_word(16'hC000, 16'h4000, 16'h8000, 32'hFFFF_FFFF,  1'b0);
        // no time passes, then a step back seen as a long forward step
        queue_word(16'h0100, 16'h0200, 16'h7FFF, 32'hFFFF_FFFF,  1'b0);
        queue_word(16'h0100, 16'h0200, 16'h0100, 32'hFFFF_FFF0,  1'b0);
        // timestamp wrap
        queue_word(16'hF000, 16'h0800, 16'h0200, 32'h0000_0010,  1'b0);
        queue_word(16'h0800, 16'hF000, 16'hFE00, 32'h0000_0400,  1'b0);
        settle();

        // register extremes, upper data bits set to check masking
        idle_odds = 25;
        stamp_cursor = 32'hFFFF_0000;
        program_filter(20'hF8000, 20'hFFFFF, 20'hFFFFF);
        run_random(60);
        settle();

        idle_odds = 35;
        program_filter(20'h07FFF, 20'h00000, 20'h00000);
        run_random(60);
        settle();

        for (p = 0; p < 6; p++) begin
            case (p)
                2, 5:    idle_odds = 0;
                1:       idle_odds = 50;
                default: idle_odds = 15;
            endcase
            program_filter(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                           (p == 3) ? RST_GYRO_GAIN : CFG_DATA_W'($urandom));
            run_random(70);
            settle();
        end

        $display("run covered %0d words over %0d register settings, %0d angle pairs checked",
                 words_sent, settings_used, angles_checked);
        if (fail_count == 0) begin
            $display("[tilt_complementary_filter_top] OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("[tilt_complementary_filter_top] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d of %0d words sent", words_sent, words_queued);
        $display("[tilt_complementary_filter_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tcf_pkg.sv
sv/tcf_ctrl.sv
sv/tcf_datapath.sv
sv/tilt_complementary_filter_top.sv
bench/tilt_complementary_filter_top_tb.sv
